// File: rtl/core/lfbr_pkg.sv
// ----------------------------------------------------------------------------
// lfbr_pkg: shared types and constants of the LSB-first bit reader
// Item and result formats, queue entry format, opcode and command codes.
// ----------------------------------------------------------------------------
package lfbr_pkg;

  // Field and state widths
  localparam int OPCODE_W = 3;
  localparam int BITS_W   = 6;
  localparam int ADDR_W   = 12;
  localparam int DATA_W   = 8;
  localparam int VALUE_W  = 32;
  localparam int COUNT_W  = 13;
  localparam int POS_W    = 17;
  localparam int PADDR_W  = 2;

  localparam logic [POS_W-1:0]  POS_MAX  = '1;
  localparam logic [BITS_W-1:0] MAX_BITS = 6'd32;

  // Input opcodes
  localparam logic [OPCODE_W-1:0] OP_WRITE   = 3'd0;
  localparam logic [OPCODE_W-1:0] OP_READ    = 3'd1;
  localparam logic [OPCODE_W-1:0] OP_LOOK    = 3'd2;
  localparam logic [OPCODE_W-1:0] OP_ADVANCE = 3'd3;
  localparam logic [OPCODE_W-1:0] OP_REWIND  = 3'd4;

  // Classified command kinds carried through the queue
  localparam logic [2:0] K_NOP     = 3'd0;
  localparam logic [2:0] K_WRITE   = 3'd1;
  localparam logic [2:0] K_READ    = 3'd2;
  localparam logic [2:0] K_LOOK    = 3'd3;
  localparam logic [2:0] K_ADVANCE = 3'd4;
  localparam logic [2:0] K_REWIND  = 3'd5;

  // Register byte addresses
  localparam logic [PADDR_W-1:0] REG_BYTE_COUNT = 2'd0;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [BITS_W-1:0]   bit_count;
    logic [ADDR_W-1:0]   byte_address;
    logic [DATA_W-1:0]   byte_data;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               overflow;
  } result_t;

  typedef struct packed {
    logic [2:0]        kind;
    logic [BITS_W-1:0] count;
    logic [ADDR_W-1:0] byte_address;
    logic [DATA_W-1:0] byte_data;
  } cmd_t;

  // Queue status (valid, full) as seen by the back end
  typedef struct packed {
    logic valid;
    logic full;
  } q_status_t;

endpackage

// File: rtl/core/lfbr_front.sv
// ----------------------------------------------------------------------------
// lfbr_front: item intake and classification
// Takes a transaction on start, decodes the opcode into a command kind and
// clamps the bit count to 32 before the command enters the queue.
// ----------------------------------------------------------------------------
module lfbr_front (
  input  logic            start,
  input  logic            busy,
  input  lfbr_pkg::item_t item,
  output logic            push,
  output lfbr_pkg::cmd_t  cmd
);
  import lfbr_pkg::*;

  assign push = start && !busy;

  // Opcode to command kind; bit counts above 32 behave as 32
  always_comb begin
    case (item.opcode)
      OP_WRITE:   cmd.kind = K_WRITE;
      OP_READ:    cmd.kind = K_READ;
      OP_LOOK:    cmd.kind = K_LOOK;
      OP_ADVANCE: cmd.kind = K_ADVANCE;
      OP_REWIND:  cmd.kind = K_REWIND;
      default:    cmd.kind = K_NOP;
    endcase
    cmd.count        = (item.bit_count > MAX_BITS) ? MAX_BITS : item.bit_count;
    cmd.byte_address = item.byte_address;
    cmd.byte_data    = item.byte_data;
  end

endmodule

// File: rtl/core/lfbr_queue.sv
// ----------------------------------------------------------------------------
// lfbr_queue: two-entry command queue
// Decouples intake from execution; full stalls the front, empty idles the back.
// ----------------------------------------------------------------------------
module lfbr_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  lfbr_pkg::cmd_t       push_cmd,
  input  logic                 pop,
  output lfbr_pkg::cmd_t       head,
  output lfbr_pkg::q_status_t  status
);
  import lfbr_pkg::*;

  cmd_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  assign head         = entries[rd_ptr];
  assign status.valid = (count != 2'd0);
  assign status.full  = (count == 2'd2);

  // Checks
  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    !(push && status.full)) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    !(pop && !status.valid)) else $error("pop from empty queue");
  a_fill_grows: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue level did not grow");

endmodule

// File: rtl/core/lfbr_back.sv
// ----------------------------------------------------------------------------
// lfbr_back: command execution and byte store
// Issue step: bit position update, overflow check, store write and banked
// read. Align step: byte alignment, shift and mask into the result register.
// ----------------------------------------------------------------------------
module lfbr_back #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lfbr_pkg::q_status_t           status,
  input  lfbr_pkg::cmd_t                head,
  input  logic [lfbr_pkg::COUNT_W-1:0]  byte_count,
  output logic                          pop,
  output logic                          done,
  output lfbr_pkg::result_t             result
);
  import lfbr_pkg::*;

  // Store is eight byte-wide banks, bank = address mod 8
  localparam int BANK_ROWS = (BUFFER_BYTES + 7) / 8;
  localparam int ROW_W     = (BANK_ROWS > 1) ? $clog2(BANK_ROWS) : 1;
  localparam int CNT_W     = POS_W;
  localparam logic [CNT_W-1:0] BUF_LIMIT = CNT_W'(BUFFER_BYTES);

  logic [POS_W-1:0]   pos;
  logic [POS_W:0]     pos_sum;
  logic [POS_W-1:0]   pos_adv;
  logic [CNT_W-1:0]   cnt_ext;
  logic [CNT_W-1:0]   cnt_eff;
  logic [CNT_W+2:0]   bit_limit;
  logic [CNT_W+2:0]   bit_need;
  logic               ovf;
  logic               is_extract;
  logic [VALUE_W:0]   mask_wide;
  logic [10:0]        row0;
  logic               wr_en;
  logic [ROW_W-1:0]   wr_row;
  logic [ROW_W-1:0]   rd_row [8];
  logic [DATA_W-1:0]  rd_data [8];

  // Stage one registers
  logic               s1_valid;
  logic               s1_extract;
  logic               s1_ovf;
  logic [2:0]         s1_lo;
  logic [2:0]         s1_sh;
  logic [VALUE_W-1:0] s1_mask;

  logic [8*5-1:0]     window;
  logic [8*5-1:0]     shifted;

  assign pop        = status.valid;
  assign is_extract = (head.kind == K_READ) || (head.kind == K_LOOK);

  // Valid bytes, capped at the store size, and the overflow test
  assign cnt_ext   = CNT_W'(byte_count);
  assign cnt_eff   = (cnt_ext > BUF_LIMIT) ? BUF_LIMIT : cnt_ext;
  assign bit_limit = {cnt_eff, 3'b000};
  assign bit_need  = (CNT_W+3)'(pos) + (CNT_W+3)'(head.count);
  assign ovf       = bit_need > bit_limit;

  // Saturating position advance
  assign pos_sum = {1'b0, pos} + (POS_W+1)'(head.count);
  assign pos_adv = pos_sum[POS_W] ? POS_MAX : pos_sum[POS_W-1:0];

  // Position register
  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (pop) begin
      case (head.kind)
        K_READ, K_ADVANCE: pos <= pos_adv;
        K_REWIND:          pos <= '0;
        default:           pos <= pos;
      endcase
    end
  end

  // Bank addressing: banks below the start bank take the next row
  assign row0   = pos[POS_W-1:6];
  assign wr_en  = pop && (head.kind == K_WRITE) &&
                  (32'(head.byte_address) < 32'(BUFFER_BYTES));
  assign wr_row = ROW_W'(32'(head.byte_address[ADDR_W-1:3]));

  genvar b;
  generate
    for (b = 0; b < 8; b++) begin : g_bank
      logic [DATA_W-1:0] mem [2**ROW_W];

      assign rd_row[b] = (3'(b) >= pos[5:3]) ? ROW_W'(32'(row0)) :
                                               ROW_W'(32'(row0) + 32'd1);

      always_ff @(posedge clk) begin
        if (wr_en && (head.byte_address[2:0] == 3'(b))) begin
          mem[wr_row] <= head.byte_data;
        end
        rd_data[b] <= mem[rd_row[b]];
      end
    end
  endgenerate

  // Result mask of count ones
  assign mask_wide = ((VALUE_W+1)'(1) << head.count) - (VALUE_W+1)'(1);

  // Stage one
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    s1_extract <= is_extract;
    s1_ovf     <= is_extract && ovf;
    s1_lo      <= pos[5:3];
    s1_sh      <= pos[2:0];
    s1_mask    <= mask_wide[VALUE_W-1:0];
  end

  // Gather five consecutive bytes from the banks, then align
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      window[8*i +: 8] = rd_data[3'(s1_lo + 3'(i))];
    end
  end
  assign shifted = window >> s1_sh;

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ovf) begin
      result.value <= '1;
    end else if (s1_extract) begin
      result.value <= shifted[VALUE_W-1:0] & s1_mask;
    end else begin
      result.value <= '0;
    end
    result.overflow <= s1_ovf;
  end

  // Checks
  a_ovf_all_ones: assert property (@(posedge clk) disable iff (rst)
    (done && result.overflow) |-> (result.value == '1))
    else $error("overflow result not all ones");
  a_rewind_zero: assert property (@(posedge clk) disable iff (rst)
    (pop && head.kind == K_REWIND) |=> (pos == '0))
    else $error("rewind left position non-zero");
  a_look_holds: assert property (@(posedge clk) disable iff (rst)
    (pop && (head.kind == K_LOOK || head.kind == K_WRITE)) |=> $stable(pos))
    else $error("position moved on look or write");

endmodule

// File: rtl/core/lsb_first_bit_reader.sv
// ----------------------------------------------------------------------------
// lsb_first_bit_reader: LSB-first packed-bit reader
// Byte store written by address; read, look, advance and rewind over a bit
// position, least significant bit of each byte first.
// ----------------------------------------------------------------------------
//
//   channel   | handshake                        | payload
//   ----------+----------------------------------+-------------------------
//   command   | start, busy (accept: start&!busy)| item (item_t)
//   result    | done strobe, one cycle           | result (result_t)
//   registers | APB psel/penable/pwrite/pready   | paddr, pwdata, prdata
//
// One transaction can be taken every cycle while busy is low; an accepted
// item is written to the queue, issued from its head (banked store read) and
// then aligned into the result register, where done is raised with it.
// busy would rise only with the two-entry queue full; the back end drains one
// entry every cycle, so it stays low.
// Reset clears the bit position, byte_count and the pipeline; store contents
// are undefined until written. The receiver cannot stall results.
module lsb_first_bit_reader #(
  parameter int BUFFER_BYTES = 4096
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  lfbr_pkg::item_t               item,
  output logic                          done,
  output lfbr_pkg::result_t             result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfbr_pkg::PADDR_W-1:0]  paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);
  import lfbr_pkg::*;

  logic              push;
  cmd_t              push_cmd;
  cmd_t              head;
  q_status_t         status;
  logic              pop;
  logic [COUNT_W-1:0] byte_count;

  // Register port
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_BYTE_COUNT)) begin
      byte_count <= pwdata[COUNT_W-1:0];
    end
  end

  assign prdata = (paddr == REG_BYTE_COUNT) ? 32'(byte_count) : 32'd0;

  assign busy = status.full;

  lfbr_front u_front (
    .start (start),
    .busy  (busy),
    .item  (item),
    .push  (push),
    .cmd   (push_cmd)
  );

  lfbr_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head     (head),
    .status   (status)
  );

  lfbr_back #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .status     (status),
    .head       (head),
    .byte_count (byte_count),
    .pop        (pop),
    .done       (done),
    .result     (result)
  );

endmodule
